// ----- hw/rtl/ffba_pkg.sv -----
`default_nettype none
package ffba_pkg;
    localparam int POOL_WORDS   = 1024;
    localparam int WORD_BYTES   = 8;
    localparam int HEADER_BYTES = 8;
    localparam int ADDR_W       = $clog2(POOL_WORDS);
    localparam int WORD_SHIFT   = $clog2(WORD_BYTES);
    localparam int HDR_W        = 15;
    localparam int OFS_W        = 16;
    localparam int POOL_MIN     = 2 * HEADER_BYTES + 2 * WORD_BYTES;
    localparam int POOL_MAX     = POOL_WORDS * WORD_BYTES;
    localparam int POOL_RESET   = 8192;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_LARGEST = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [12:0] request_bytes;
        logic [12:0] free_offset;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [12:0] payload_offset;
        logic [12:0] largest_bytes;
    } t_out_word;
endpackage
`default_nettype wire

// ----- hw/rtl/first_fit_block_allocator.sv -----
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   i_in_word  (t_in_word)
// out      output     o_out_valid / i_out_ready o_out_word (t_out_word)
// cfg      input      i_cfg_we                  i_cfg_data (pool bytes)
// each header visited is read, then evaluated, in its own state on the header
// ram; an ignored free, zero-size allocate or unused code goes straight to the
// result, and a split adds a write of the second free header.
// reset and every pool size write start a clearing pass over all 1024 header
// ram entries, during which no word is accepted.
// a finished word waits in the output register while the next is taken.
`default_nettype none
module first_fit_block_allocator (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire ffba_pkg::t_in_word i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output ffba_pkg::t_out_word o_out_word,
    input  wire                 i_cfg_we,
    input  wire [13:0]          i_cfg_data
);
    import ffba_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [OFS_W-1:0] HDR  = OFS_W'(HEADER_BYTES);
    localparam logic [OFS_W-1:0] WRD  = OFS_W'(WORD_BYTES);

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [12:0]       r_req, n_req;
    logic [OFS_W-1:0]  r_padded, n_padded;
    logic [OFS_W-1:0]  r_p, n_p;
    logic [OFS_W-1:0]  r_start, n_start;
    logic [OFS_W-1:0]  r_sum, n_sum;
    logic [OFS_W-1:0]  r_space, n_space;
    logic [OFS_W-1:0]  r_best, n_best;
    logic              r_in_span, n_in_span;
    logic              r_pvalid, n_pvalid;
    t_out_word         r_res, n_res;
    t_out_word         r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [13:0]       r_pool, n_pool;
    logic              r_clr_busy, n_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [HDR_W-1:0]  ram_wdata, ram_rdata;

    logic signed [OFS_W-1:0] h16;
    logic [OFS_W-1:0]        sz, step_used, step_free;
    logic [OFS_W-1:0]        sum_new, space_new;
    logic [13:0]             cfg_clamped;
    logic [OFS_W-1:0]        pool_hdr;
    logic [OFS_W-1:0]        split_p;

    ffba_ram #(.WIDTH(HDR_W), .DEPTH(POOL_WORDS)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !r_clr_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // headers outside the pool read as the end marker
    assign h16       = r_pvalid ? OFS_W'($signed(ram_rdata)) : '0;
    assign sz        = OFS_W'(-h16);
    assign step_used = r_p + OFS_W'(h16) + HDR;
    assign step_free = r_p + sz + HDR;
    assign sum_new   = r_in_span ? r_sum + sz : sz;
    assign space_new = r_in_span ? r_space + sz + HDR : sz;
    assign pool_hdr  = OFS_W'(r_pool) - (HDR << 1);
    assign split_p   = r_start + HDR + r_padded;

    always_comb begin
        if (i_cfg_data < 14'(POOL_MIN)) begin
            cfg_clamped = 14'(POOL_MIN);
        end else if (i_cfg_data > 14'(POOL_MAX)) begin
            cfg_clamped = 14'(POOL_MAX);
        end else begin
            cfg_clamped = i_cfg_data;
        end
        cfg_clamped[WORD_SHIFT-1:0] = '0;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_req       = r_req;
        n_padded    = r_padded;
        n_p         = r_p;
        n_start     = r_start;
        n_sum       = r_sum;
        n_space     = r_space;
        n_best      = r_best;
        n_in_span   = r_in_span;
        n_pvalid    = r_pvalid;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_pool      = r_pool;
        n_clr_busy  = r_clr_busy;
        n_clr_addr  = r_clr_addr;
        ram_we      = 1'b0;
        ram_waddr   = r_p[WORD_SHIFT +: ADDR_W];
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_p[WORD_SHIFT +: ADDR_W];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (r_clr_busy) begin
            // the free block header goes in at entry zero during the sweep
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = (r_clr_addr == '0) ? HDR_W'(-$signed(pool_hdr)) : '0;
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(POOL_WORDS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_op      = i_in_word.opcode;
                    n_req     = i_in_word.request_bytes;
                    n_padded  = (OFS_W'(i_in_word.request_bytes) + WRD - 1'b1)
                                & ~(WRD - 1'b1);
                    n_p       = '0;
                    n_best    = '0;
                    n_in_span = 1'b0;
                    n_res     = '0;
                    n_state   = S_DONE;
                    unique case (i_in_word.opcode)
                        OP_ALLOC: begin
                            if (i_in_word.request_bytes == '0) begin
                                n_res.status = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_FREE: begin
                            if (OFS_W'(i_in_word.free_offset) >= HDR &&
                                i_in_word.free_offset[WORD_SHIFT-1:0] == '0 &&
                                OFS_W'(i_in_word.free_offset) <= OFS_W'(r_pool)) begin
                                n_p     = OFS_W'(i_in_word.free_offset) - HDR;
                                n_state = S_RD;
                            end
                        end
                        OP_LARGEST: n_state = S_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_RD: begin
                ram_re   = 1'b1;
                n_pvalid = ({1'b0, r_p} + {1'b0, HDR}) <= (OFS_W + 1)'(r_pool);
                n_state  = S_EV;
            end
            S_EV: begin
                if (r_op == OP_FREE) begin
                    ram_we    = 1'b1;
                    ram_wdata = (h16 > 0) ? HDR_W'(-h16) : HDR_W'(h16);
                    n_state   = S_DONE;
                end else if (h16 < 0) begin
                    if (!r_in_span) begin
                        n_start = r_p;
                    end
                    n_in_span = 1'b1;
                    n_sum     = sum_new;
                    n_space   = space_new;
                    n_p       = step_free;
                    if (r_op == OP_ALLOC && sum_new >= OFS_W'(r_req)) begin
                        n_state = S_DEC;
                    end else begin
                        n_state = S_RD;
                    end
                end else if (r_in_span) begin
                    // span hit a used block or end; re-read unless alloc fits
                    if (r_op == OP_ALLOC) begin
                        n_state = S_DEC;
                    end else begin
                        if (r_space > r_best) begin
                            n_best = r_space;
                        end
                        n_in_span = 1'b0;
                        n_state   = S_RD;
                    end
                end else if (h16 == 0) begin
                    if (r_op == OP_ALLOC) begin
                        n_res.status = 1'b1;
                    end else begin
                        n_res.largest_bytes = r_best[12:0];
                    end
                    n_state = S_DONE;
                end else begin
                    n_p     = step_used;
                    n_state = S_RD;
                end
            end
            S_DEC: begin
                ram_waddr = r_start[WORD_SHIFT +: ADDR_W];
                n_res.payload_offset = 13'(r_start + HDR);
                if (r_padded + HDR + WRD <= r_space) begin
                    ram_we    = 1'b1;
                    ram_wdata = HDR_W'(r_padded);
                    n_state   = S_WR2;
                end else if (r_padded <= r_space) begin
                    ram_we    = 1'b1;
                    ram_wdata = HDR_W'(r_space);
                    n_state   = S_DONE;
                end else begin
                    n_res.payload_offset = '0;
                    n_in_span = 1'b0;
                    n_state   = S_RD;
                end
            end
            S_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = split_p[WORD_SHIFT +: ADDR_W];
                ram_wdata = HDR_W'(-$signed(r_space - HDR - r_padded));
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            n_pool     = cfg_clamped;
            n_clr_busy = 1'b1;
            n_clr_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pool      <= 14'(POOL_RESET);
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pool      <= n_pool;
            r_clr_busy  <= n_clr_busy;
            r_clr_addr  <= n_clr_addr;
        end
        r_op      <= n_op;
        r_req     <= n_req;
        r_padded  <= n_padded;
        r_p       <= n_p;
        r_start   <= n_start;
        r_sum     <= n_sum;
        r_space   <= n_space;
        r_best    <= n_best;
        r_in_span <= n_in_span;
        r_pvalid  <= n_pvalid;
        r_res     <= n_res;
        r_out     <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> r_state == S_IDLE)
        else $error("clearing pass overlaps a word");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("finished word not presented");

    a_payload_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.status) |->
            o_out_word.payload_offset[WORD_SHIFT-1:0] == '0)
        else $error("payload offset not word aligned");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/ffba_ram.sv -----
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
module tb;
    import ffba_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 4200;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;
    logic      i_cfg_we = 1'b0;
    logic [13:0] i_cfg_data = '0;

    first_fit_block_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the header list
    int          heap_hdr [POOL_WORDS];
    int unsigned heap_bytes;
    t_out_word   expected_words [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    int          quiet_cycles = 0;
    bit          timed_out = 1'b0;
    int unsigned live_offsets [$];

    function automatic int hdr_get(int unsigned p);
        if ((p % WORD_BYTES) != 0 || p + HEADER_BYTES > heap_bytes) return 0;
        return heap_hdr[(p / WORD_BYTES) % POOL_WORDS];
    endfunction

    function automatic void hdr_put(int unsigned p, int v);
        if ((p % WORD_BYTES) != 0 || p + HEADER_BYTES > heap_bytes) return;
        heap_hdr[(p / WORD_BYTES) % POOL_WORDS] = v;
    endfunction

    function automatic void heap_rebuild(int unsigned b);
        if (b < POOL_MIN) b = POOL_MIN;
        if (b > POOL_MAX) b = POOL_MAX;
        b -= b % WORD_BYTES;
        heap_bytes = b;
        foreach (heap_hdr[k]) heap_hdr[k] = 0;
        hdr_put(0, -int'(b - 2 * HEADER_BYTES));
        hdr_put(b - HEADER_BYTES, 0);
    endfunction

    function automatic int unsigned skip_allocated(int unsigned p);
        int v;
        v = hdr_get(p);
        while (v > 0) begin
            p += v + HEADER_BYTES;
            v = hdr_get(p);
        end
        return p;
    endfunction

    function automatic int unsigned merged_span(int unsigned p, int unsigned need, bit stop);
        int unsigned sum, n;
        int v;
        sum = 0;
        n = 0;
        v = hdr_get(p);
        while (v < 0) begin
            n++;
            sum += -v;
            p += -v + HEADER_BYTES;
            if (stop && sum >= need) break;
            v = hdr_get(p);
        end
        return n ? sum + (n - 1) * HEADER_BYTES : 0;
    endfunction

    function automatic int unsigned first_fit(int unsigned req);
        int unsigned padded, p, space;
        if (req == 0) return 0;
        padded = (req + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
        p = 0;
        while (hdr_get(p) != 0) begin
            p = skip_allocated(p);
            if (hdr_get(p) == 0) break;
            space = merged_span(p, req, 1'b1);
            if (padded + HEADER_BYTES + WORD_BYTES <= space) begin
                hdr_put(p, padded);
                hdr_put(p + HEADER_BYTES + padded, -int'(space - HEADER_BYTES - padded));
                return p + HEADER_BYTES;
            end
            if (padded <= space) begin
                hdr_put(p, space);
                return p + HEADER_BYTES;
            end
            p += HEADER_BYTES + space;
        end
        return 0;
    endfunction

    function automatic int unsigned largest_span();
        int unsigned p, best, space;
        p = 0;
        best = 0;
        while (hdr_get(p) != 0) begin
            p = skip_allocated(p);
            if (hdr_get(p) == 0) break;
            space = merged_span(p, 0, 1'b0);
            if (space > best) best = space;
            p += HEADER_BYTES + space;
        end
        return best;
    endfunction

    function automatic t_out_word predict_word(t_in_word w);
        t_out_word r;
        int unsigned p;
        int v;
        r = '0;
        case (w.opcode)
            OP_ALLOC: begin
                r.payload_offset = 13'(first_fit(w.request_bytes));
                r.status = (r.payload_offset == 0);
            end
            OP_FREE: begin
                if (w.free_offset >= HEADER_BYTES) begin
                    p = w.free_offset - HEADER_BYTES;
                    if ((p % WORD_BYTES) == 0 && p + HEADER_BYTES <= heap_bytes) begin
                        v = hdr_get(p);
                        hdr_put(p, v > 0 ? -v : v);
                    end
                end
            end
            OP_LARGEST: r.largest_bytes = 13'(largest_span());
            default: ;
        endcase
        return r;
    endfunction

    // valid stays high after acceptance until the caller idles or sends again
    task automatic send_word(logic [1:0] op, int unsigned req, int unsigned ofs);
        t_in_word w;
        t_out_word r;
        w.opcode = op;
        w.request_bytes = 13'(req);
        w.free_offset = 13'(ofs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        r = predict_word(w);
        expected_words.push_back(r);
        if (op == OP_ALLOC && r.status == 1'b0) live_offsets.push_back(r.payload_offset);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES / 100) @(posedge i_clk);
    endtask

    task automatic write_pool(int unsigned b);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= 14'(b);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        heap_rebuild(b & 14'h3fff);
        live_offsets.delete();
    endtask

    task automatic random_word();
        int unsigned sel, k;
        sel = $urandom_range(99);
        if (sel < 45) begin
            if ($urandom_range(9) < 8) send_word(OP_ALLOC, $urandom_range(1, 200), 0);
            else send_word(OP_ALLOC, $urandom_range(0, 8191), 0);
        end else if (sel < 85 && live_offsets.size() != 0) begin
            k = $urandom_range(live_offsets.size() - 1);
            send_word(OP_FREE, $urandom, live_offsets[k]);
            live_offsets.delete(k);
        end else if (sel < 92) begin
            send_word(OP_LARGEST, $urandom, $urandom);
        end else if (sel < 97) begin
            send_word(OP_FREE, $urandom, $urandom_range(0, 8191));
        end else begin
            send_word(OP_UNUSED, $urandom, $urandom);
        end
    endtask

    task automatic test_directed();
        send_word(OP_LARGEST, 0, 0);
        send_word(OP_ALLOC, 0, 0);
        send_word(OP_ALLOC, 1, 0);
        send_word(OP_ALLOC, 8, 0);
        send_word(OP_ALLOC, 9, 0);
        send_word(OP_ALLOC, 8191, 0);
        send_word(OP_FREE, 0, 0);
        send_word(OP_FREE, 0, 4);
        send_word(OP_FREE, 0, 13);
        send_word(OP_FREE, 0, 8191);
        send_word(OP_FREE, 0, 8);
        send_word(OP_FREE, 0, 8);
        send_word(OP_FREE, 0, 24);
        send_word(OP_ALLOC, 4, 0);
        send_word(OP_UNUSED, 13'h1fff, 13'h1fff);
        send_word(OP_LARGEST, 13'h1fff, 13'h1fff);
        send_word(OP_ALLOC, 8160, 0);
        send_word(OP_ALLOC, 8168, 0);
        send_word(OP_LARGEST, 0, 0);
    endtask

    task automatic test_small_pool();
        write_pool(0);
        send_word(OP_LARGEST, 0, 0);
        send_word(OP_ALLOC, 8, 0);
        send_word(OP_ALLOC, 1, 0);
        send_word(OP_FREE, 0, 8);
        send_word(OP_ALLOC, 16, 0);
        send_word(OP_ALLOC, 17, 0);
        write_pool(37);
        repeat (60) random_word();
        write_pool(14'h3fff);
        send_word(OP_LARGEST, 0, 0);
    endtask

    task automatic test_random_phases();
        int unsigned idle_set [4] = '{0, 58, 0, 33};
        int unsigned stall_set [4] = '{0, 0, 58, 33};
        int unsigned sizes [4] = '{512, 8192, 1000, 2048};
        for (int ph = 0; ph < 4; ph++) begin
            write_pool(sizes[ph]);
            send_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            repeat (440) random_word();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_pool(8192);
        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            repeat (30) random_word();
        join
        drain_results();
        repeat (30) random_word();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected word %h", o_out_word);
            end else begin
                e = expected_words.pop_front();
                if (o_out_word.status !== e.status
                    || o_out_word.payload_offset !== e.payload_offset
                    || o_out_word.largest_bytes !== e.largest_bytes) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected st=%0d ofs=%0d lg=%0d, got st=%0d ofs=%0d lg=%0d",
                                 e.status, e.payload_offset, e.largest_bytes, o_out_word.status,
                                 o_out_word.payload_offset, o_out_word.largest_bytes);
                end
            end
        end
    end

    // counts cycles without any accepted word; clearing passes fit well inside
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        heap_rebuild(POOL_RESET);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_small_pool();
        test_random_phases();
        test_backpressure();
        drain_results();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ram.sv
hw/rtl/first_fit_block_allocator.sv
bench/tb.sv
